FILE: hw/rtl/isc_pkg.sv
// Shared types, constants and helper functions of the info string token checker.
package isc_pkg;

  // Default longest string (exclusive) and the largest usable token length.
  localparam int unsigned MaxInfo    = 1024;
  localparam int unsigned TokenBytes = 16;

  // Register map: 64-bit registers at byte address 8*i.
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 64;

  typedef enum logic [1:0] {
    RegTokenLow  = 2'd0,
    RegTokenHigh = 2'd1,
    RegTokenLen  = 2'd2,
    RegUnused    = 2'd3
  } reg_index_e;

  // Parser phase within one key/value pair.
  typedef enum logic [1:0] {
    PhOpen  = 2'd0,
    PhKey   = 2'd1,
    PhValue = 2'd2
  } phase_e;

  // Special characters and the printable range.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChFirstPrn  = 8'd32;
  localparam logic [7:0] ChDelete    = 8'd127;
  localparam logic [3:0] TagLen      = 4'd9;

  // Configured token as seen by the parser.
  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  len;
  } token_cfg_t;

  // Printable ASCII other than the double quote and the semicolon.
  function automatic logic byte_allowed(input logic [7:0] c);
    return (c >= ChFirstPrn) && (c < ChDelete) && (c != ChQuote) && (c != ChSemicolon);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Letters of the tag key "challenge"; positions past its end read as zero.
  function automatic logic [7:0] tag_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "c";
      4'd1:    ch = "h";
      4'd2:    ch = "a";
      4'd3:    ch = "l";
      4'd4:    ch = "l";
      4'd5:    ch = "e";
      4'd6:    ch = "n";
      4'd7:    ch = "g";
      4'd8:    ch = "e";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/isc_if.sv
// Stream interfaces for the text bytes and the verdict words.
interface isc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface isc_out_if;
  logic valid;
  logic ready;
  logic token_accepted;

  modport source (output valid, output token_accepted, input ready);
  modport sink   (input valid, input token_accepted, output ready);
endinterface

FILE: hw/rtl/isc_cfg_regs.sv
// APB-style register file holding the expected token and its length.
module isc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [isc_pkg::AddrWidth-1:0]       paddr,
  input  logic [isc_pkg::DataWidth-1:0]       pwdata,
  output logic [isc_pkg::DataWidth-1:0]       prdata,
  output logic                                pready,
  output isc_pkg::token_cfg_t                 cfg_o
);

  logic [63:0]        low_q;
  logic [63:0]        high_q;
  logic [4:0]         len_q;
  logic               wr_en;
  isc_pkg::reg_index_e idx;

  assign pready = 1'b1;
  assign idx    = isc_pkg::reg_index_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      len_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        isc_pkg::RegTokenLow:  low_q  <= pwdata;
        isc_pkg::RegTokenHigh: high_q <= pwdata;
        isc_pkg::RegTokenLen:  len_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      isc_pkg::RegTokenLow:  prdata = low_q;
      isc_pkg::RegTokenHigh: prdata = high_q;
      isc_pkg::RegTokenLen:  prdata = {59'd0, len_q};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = '{low: low_q, high: high_q, len: len_q};

endmodule

FILE: hw/rtl/isc_parser.sv
// Input register, per-string parse state and verdict register.
module isc_parser #(
  parameter int unsigned MAX_INFO = isc_pkg::MaxInfo
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isc_pkg::token_cfg_t cfg_i,
  isc_in_if.sink              in_if,
  isc_out_if.source           out_if
);

  localparam int unsigned CntWidth = $clog2(MAX_INFO + 1);
  localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_INFO);

  // Input register.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       fin_q;
  logic       advance;

  // Parse state.
  isc_pkg::phase_e     phase_q, phase_d;
  logic [3:0]          kpos_q, kpos_d;
  logic                kdiff_q, kdiff_d;
  logic [4:0]          vpos_q, vpos_d;
  logic                vdiff_q, vdiff_d;
  logic                seen_q, seen_d;
  logic                failed_q, failed_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                ok;

  // Result register.
  logic out_vld_q;
  logic res_q;

  logic [127:0] token_word;
  logic [7:0]   token_chr;

  // A final word may move on only once the result register is free.
  assign advance     = in_vld_q && (!fin_q || !out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      byte_q <= in_if.text_byte;
      fin_q  <= in_if.final_byte;
    end
  end

  assign token_word = {cfg_i.high, cfg_i.low};
  assign token_chr  = token_word[{vpos_q[3:0], 3'b000} +: 8];

  // Next parse state for the word in the input register.
  always_comb begin
    phase_d  = phase_q;
    kpos_d   = kpos_q;
    kdiff_d  = kdiff_q;
    vpos_d   = vpos_q;
    vdiff_d  = vdiff_q;
    seen_d   = seen_q;
    cnt_d    = (cnt_q < CntMax) ? cnt_q + CntWidth'(1) : cnt_q;
    failed_d = failed_q || (cnt_d >= CntMax);
    ok       = 1'b0;

    if (!failed_d) begin
      case (phase_q)
        isc_pkg::PhOpen: begin
          if (byte_q != isc_pkg::ChBackslash) begin
            failed_d = 1'b1;
          end else begin
            phase_d = isc_pkg::PhKey;
            kpos_d  = '0;
            kdiff_d = 1'b0;
          end
        end
        isc_pkg::PhKey: begin
          if (byte_q == isc_pkg::ChBackslash) begin
            if (kpos_q == '0) begin
              failed_d = 1'b1;
            end else begin
              if (kpos_q != isc_pkg::TagLen) kdiff_d = 1'b1;
              phase_d = isc_pkg::PhValue;
              vpos_d  = '0;
              vdiff_d = 1'b0;
            end
          end else if (!isc_pkg::byte_allowed(byte_q)) begin
            failed_d = 1'b1;
          end else begin
            if (kpos_q >= isc_pkg::TagLen ||
                isc_pkg::to_lower(byte_q) != isc_pkg::tag_char(kpos_q)) begin
              kdiff_d = 1'b1;
            end
            if (kpos_q != 4'd15) kpos_d = kpos_q + 4'd1;
          end
        end
        isc_pkg::PhValue: begin
          if (byte_q == isc_pkg::ChBackslash) begin
            // Close the pair, then open the next key.
            if (!kdiff_q) begin
              if (seen_q || vdiff_q || vpos_q != cfg_i.len) failed_d = 1'b1;
              else seen_d = 1'b1;
            end
            phase_d = isc_pkg::PhKey;
            kpos_d  = '0;
            kdiff_d = 1'b0;
          end else if (!isc_pkg::byte_allowed(byte_q)) begin
            failed_d = 1'b1;
          end else begin
            if (!kdiff_q && (vpos_q >= cfg_i.len || vpos_q[4] || byte_q != token_chr)) begin
              vdiff_d = 1'b1;
            end
            if (vpos_q != 5'd31) vpos_d = vpos_q + 5'd1;
          end
        end
        default: failed_d = 1'b1;
      endcase
    end

    // End of string: close the open pair and form the verdict.
    if (fin_q) begin
      if (!failed_d) begin
        if (phase_d == isc_pkg::PhValue) begin
          if (!kdiff_d) begin
            if (seen_d || vdiff_d || vpos_d != cfg_i.len) failed_d = 1'b1;
            else seen_d = 1'b1;
          end
        end else begin
          failed_d = 1'b1;
        end
      end
      ok = !failed_d && seen_d && (cfg_i.len != '0) &&
           (cfg_i.len <= 5'(isc_pkg::TokenBytes));
      phase_d  = isc_pkg::PhOpen;
      kpos_d   = '0;
      kdiff_d  = 1'b0;
      vpos_d   = '0;
      vdiff_d  = 1'b0;
      seen_d   = 1'b0;
      failed_d = 1'b0;
      cnt_d    = '0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= isc_pkg::PhOpen;
      kpos_q   <= '0;
      kdiff_q  <= 1'b0;
      vpos_q   <= '0;
      vdiff_q  <= 1'b0;
      seen_q   <= 1'b0;
      failed_q <= 1'b0;
      cnt_q    <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      kpos_q   <= kpos_d;
      kdiff_q  <= kdiff_d;
      vpos_q   <= vpos_d;
      vdiff_q  <= vdiff_d;
      seen_q   <= seen_d;
      failed_q <= failed_d;
      cnt_q    <= cnt_d;
    end
  end

  // Verdict register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && fin_q) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fin_q) res_q <= ok;
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.token_accepted = res_q;

endmodule

FILE: hw/rtl/info_string_token_checker.sv
// Top level of the info string token checker.
// A verdict word is set in the verdict register once the final text word has passed the input register.
// Throughput: one text word per cycle; a final word stalls only while a verdict waits.
// The single parse stage between the input and verdict registers sets this rate.
// Reset (asynchronous, active low) clears the token registers and the parse state.
module info_string_token_checker #(
  parameter int unsigned MAX_INFO = isc_pkg::MaxInfo
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  isc_in_if.sink                        in_if,
  isc_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [isc_pkg::AddrWidth-1:0] paddr,
  input  logic [isc_pkg::DataWidth-1:0] pwdata,
  output logic [isc_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  isc_pkg::token_cfg_t cfg;

  // Token configuration registers.
  isc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Byte parser and verdict stage.
  isc_parser #(
    .MAX_INFO (MAX_INFO)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

FILE: hw/rtl/isc_checker.sv
// Port-level assertions for the info string token checker, with its bind.
module isc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_final,
  input logic out_valid,
  input logic out_ready,
  input logic out_accepted,
  input logic pready
);

  // A waiting verdict holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted))
    else $error("verdict dropped or changed while stalled");

  // A new verdict must trace back to a final word that was taken earlier.
  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_final, 2))
    else $error("verdict without a preceding final word");

  // The input side stalls only behind a waiting verdict.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the verdict side is free");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind info_string_token_checker isc_checker u_isc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_final     (in_if.final_byte),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_accepted (out_if.token_accepted),
  .pready       (pready)
);

FILE: tb/sv/info_string_token_checker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the info string token checker with its own verdict predictor.
module info_string_token_checker_tb;

  localparam int unsigned NumSettings = 10;
  localparam int unsigned WordsPerSetting = 46;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam logic [71:0] TagWord = "challenge";

  // One text word as the sender presents it.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port, driven only by the main stimulus process.
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [isc_pkg::AddrWidth-1:0] paddr = '0;
  logic [isc_pkg::DataWidth-1:0] pwdata = '0;
  logic [isc_pkg::DataWidth-1:0] prdata;
  logic                          pready;

  isc_in_if  text_if();
  isc_out_if verdict_if();

  info_string_token_checker u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (text_if.sink),
    .out_if  (verdict_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and scoreboard storage.
  text_word_t  pending_words[$];
  logic [7:0]  str_buf[$];
  bit          expected_verdicts[$];
  bit          no_idle = 1'b0;
  int unsigned fault_count = 0;
  int unsigned strings_sent = 0;
  int unsigned words_queued = 0;
  int unsigned verdicts_ok = 0;
  int unsigned verdicts_rejected = 0;
  int unsigned cycle_count = 0;

  // Predictor copy of the token registers.
  logic [63:0] tok_lo;
  logic [63:0] tok_hi;
  logic [4:0]  tok_len;

  // Predictor copy of the per-string parse state.
  isc_pkg::phase_e parse_at;
  logic [3:0]      key_pos;
  bit              key_bad;
  logic [4:0]      val_pos;
  bit              val_bad;
  bit              tok_seen;
  bit              str_bad;
  int unsigned     str_words;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  function automatic bit text_char_legal(input logic [7:0] c);
    return (c >= 8'd32) && (c <= 8'd126) && (c != isc_pkg::ChQuote) &&
           (c != isc_pkg::ChSemicolon);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] tag_letter(input logic [3:0] pos);
    if (pos >= isc_pkg::TagLen) return 8'h00;
    return TagWord[8*(8-int'(pos)) +: 8];
  endfunction

  function automatic logic [7:0] cfg_token_byte(input int unsigned idx);
    logic [63:0] half;
    half = (idx < 8) ? tok_lo : tok_hi;
    return half[8*(idx%8) +: 8];
  endfunction

  task automatic clear_parse();
    parse_at = isc_pkg::PhOpen;
    key_pos = '0;
    key_bad = 1'b0;
    val_pos = '0;
    val_bad = 1'b0;
    tok_seen = 1'b0;
    str_bad = 1'b0;
    str_words = 0;
  endtask

  // A pair closes: only a tag key matters, and it must carry the one exact token.
  task automatic close_tag_pair();
    if (!key_bad) begin
      if (tok_seen || val_bad || val_pos != tok_len) str_bad = 1'b1;
      else tok_seen = 1'b1;
    end
  endtask

  task automatic open_key();
    parse_at = isc_pkg::PhKey;
    key_pos = '0;
    key_bad = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (parse_at)
      isc_pkg::PhOpen: begin
        if (c != isc_pkg::ChBackslash) str_bad = 1'b1;
        else open_key();
      end
      isc_pkg::PhKey: begin
        if (c == isc_pkg::ChBackslash) begin
          if (key_pos == 4'd0) begin
            str_bad = 1'b1;
          end else begin
            if (key_pos != isc_pkg::TagLen) key_bad = 1'b1;
            parse_at = isc_pkg::PhValue;
            val_pos = '0;
            val_bad = 1'b0;
          end
        end else if (!text_char_legal(c)) begin
          str_bad = 1'b1;
        end else begin
          if (key_pos >= isc_pkg::TagLen || fold_case(c) != tag_letter(key_pos)) key_bad = 1'b1;
          if (key_pos != 4'd15) key_pos = key_pos + 4'd1;
        end
      end
      default: begin
        if (c == isc_pkg::ChBackslash) begin
          close_tag_pair();
          open_key();
        end else if (!text_char_legal(c)) begin
          str_bad = 1'b1;
        end else begin
          if (!key_bad && (val_pos >= tok_len || val_pos >= 5'd16 ||
                           c != cfg_token_byte(val_pos)))
            val_bad = 1'b1;
          if (val_pos != 5'd31) val_pos = val_pos + 5'd1;
        end
      end
    endcase
  endtask

  // Runs one accepted word through the predictor; the last word yields a verdict.
  task automatic absorb_text_word(input logic [7:0] c, input logic last);
    if (str_words < isc_pkg::MaxInfo) str_words++;
    if (str_words >= isc_pkg::MaxInfo) str_bad = 1'b1;
    if (!str_bad) parse_char(c);
    if (last) begin
      if (!str_bad) begin
        if (parse_at == isc_pkg::PhValue) close_tag_pair();
        else str_bad = 1'b1;
      end
      expected_verdicts.push_back(!str_bad && tok_seen && tok_len != 5'd0 &&
                                  tok_len <= isc_pkg::TokenBytes);
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver, monitors and scoreboard
  // ---------------------------------------------------------------------------

  // Text driver: one word from the pending queue, with a random gap before the next.
  always @(posedge clk_i or negedge rst_ni) begin : drive_text
    text_word_t  next_word;
    int unsigned gap_left;
    if (!rst_ni) begin
      text_if.valid <= 1'b0;
      text_if.text_byte <= '0;
      text_if.final_byte <= 1'b0;
      gap_left = 0;
    end else if (!text_if.valid || text_if.ready) begin
      if (gap_left != 0) begin
        text_if.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        text_if.valid <= 1'b1;
        text_if.text_byte <= next_word.text;
        text_if.final_byte <= next_word.last;
        gap_left = no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  // Every accepted text word feeds the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && text_if.valid && text_if.ready)
      absorb_text_word(text_if.text_byte, text_if.final_byte);
  end

  // Verdict receiver: random stall after each word, checked against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : take_verdict
    int unsigned stall_left;
    int unsigned draw;
    bit          want;
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
      stall_left = 0;
    end else if (verdict_if.valid && verdict_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict with none pending: expected none, got %0b", $time,
                 verdict_if.token_accepted);
        fault_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_if.token_accepted !== want) begin
          $display("%0t: token_accepted mismatch: expected %0b, got %0b", $time, want,
                   verdict_if.token_accepted);
          fault_count++;
        end
        if (want) verdicts_ok++;
        else verdicts_rejected++;
      end
      draw = no_idle ? 0 : $urandom_range(0, 4);
      stall_left = draw;
      verdict_if.ready <= (draw == 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      verdict_if.ready <= (stall_left == 0);
    end else begin
      verdict_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus helpers
  // ---------------------------------------------------------------------------

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input isc_pkg::reg_index_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      isc_pkg::RegTokenLow:  tok_lo = val;
      isc_pkg::RegTokenHigh: tok_hi = val;
      isc_pkg::RegTokenLen:  tok_len = val[4:0];
      default: ;
    endcase
  endtask

  task automatic program_token(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len);
    write_reg(isc_pkg::RegTokenLow, lo);
    write_reg(isc_pkg::RegTokenHigh, hi);
    write_reg(isc_pkg::RegTokenLen, {59'd0, len});
  endtask

  // Waits until every word is sent and every verdict is in, then lets the pipe settle.
  task automatic drain();
    do @(posedge clk_i); while (pending_words.size() != 0 || text_if.valid);
    do @(posedge clk_i); while (expected_verdicts.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Legal key/value character other than the backslash.
  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == isc_pkg::ChQuote || c == isc_pkg::ChSemicolon || c == isc_pkg::ChBackslash);
    return c;
  endfunction

  function automatic logic [7:0] rand_illegal();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 31));
      1:       return 8'($urandom_range(127, 255));
      2:       return isc_pkg::ChQuote;
      default: return isc_pkg::ChSemicolon;
    endcase
  endfunction

  function automatic logic [63:0] rand_plain_half();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = rand_plain();
    return w;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  // Letters of the tag key in random case, up to the given count.
  task automatic push_tag_letters(input int unsigned count);
    logic [7:0] c;
    for (int unsigned i = 0; i < count; i++) begin
      c = tag_letter(4'(i));
      str_buf.push_back($urandom_range(0, 1) ? c - 8'h20 : c);
    end
  endtask

  // Token value: exact, one character changed, one short, or one too long.
  task automatic add_token_value(input int unsigned mode);
    int unsigned n;
    int unsigned at;
    logic [7:0]  c;
    n = (tok_len > 16) ? 16 : tok_len;
    for (int unsigned i = 0; i < n; i++) str_buf.push_back(cfg_token_byte(i));
    case (mode)
      1: begin
        if (n == 0) begin
          str_buf.push_back(rand_plain());
        end else begin
          at = str_buf.size() - n + $urandom_range(0, n - 1);
          do c = rand_plain(); while (c == str_buf[at]);
          str_buf[at] = c;
        end
      end
      2: if (n != 0) void'(str_buf.pop_back());
      3: str_buf.push_back(rand_plain());
      default: ;
    endcase
  endtask

  task automatic add_token_pair();
    int unsigned pick;
    str_buf.push_back(isc_pkg::ChBackslash);
    push_tag_letters(isc_pkg::TagLen);
    str_buf.push_back(isc_pkg::ChBackslash);
    pick = $urandom_range(0, 9);
    add_token_value(pick < 7 ? 0 : pick - 6);
  endtask

  // Ordinary pair, with keys that come close to the tag key now and then.
  task automatic add_other_pair();
    int unsigned at;
    str_buf.push_back(isc_pkg::ChBackslash);
    case ($urandom_range(0, 5))
      0: push_tag_letters(isc_pkg::TagLen - 1);
      1: begin
        push_tag_letters(isc_pkg::TagLen);
        str_buf.push_back(rand_plain());
      end
      2: begin
        push_tag_letters(isc_pkg::TagLen);
        at = str_buf.size() - $urandom_range(1, isc_pkg::TagLen);
        str_buf[at] = "z";
      end
      default: repeat ($urandom_range(1, 6)) str_buf.push_back(rand_plain());
    endcase
    str_buf.push_back(isc_pkg::ChBackslash);
    repeat ($urandom_range(0, 6)) str_buf.push_back(rand_plain());
  endtask

  task automatic build_pairs();
    int unsigned pick;
    int unsigned n_tok;
    pick = $urandom_range(0, 19);
    n_tok = (pick == 0) ? 0 : (pick == 1) ? 2 : 1;
    repeat ($urandom_range(0, 2)) add_other_pair();
    repeat (n_tok) add_token_pair();
    repeat ($urandom_range(0, 2)) add_other_pair();
    if (str_buf.size() == 0) add_other_pair();
  endtask

  // Well-formed string with one defect.
  task automatic break_string();
    case ($urandom_range(0, 4))
      0: str_buf[$urandom_range(0, str_buf.size() - 1)] = rand_illegal();
      1: str_buf.push_back(isc_pkg::ChBackslash);
      2: begin
        str_buf.push_back(isc_pkg::ChBackslash);
        repeat ($urandom_range(1, 3)) str_buf.push_back(rand_plain());
      end
      3: begin
        str_buf.push_front(isc_pkg::ChBackslash);
        str_buf.push_front(isc_pkg::ChBackslash);
      end
      default: begin
        void'(str_buf.pop_front());
        if (str_buf.size() == 0) str_buf.push_back(rand_plain());
      end
    endcase
  endtask

  task automatic make_random_string();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      build_pairs();
    end else if (pick < 85) begin
      build_pairs();
      break_string();
    end else begin
      repeat ($urandom_range(1, 10)) str_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // A string of exactly the given length holding one matching token pair.
  task automatic build_long(input int unsigned n);
    push_text("\\challenge\\");
    add_token_value(0);
    push_text("\\a\\");
    while (str_buf.size() < n) str_buf.push_back(rand_plain());
  endtask

  // Moves the built string to the sender, marking its last word.
  task automatic flush_string();
    text_word_t w;
    for (int i = 0; i < str_buf.size(); i++) begin
      w.text = str_buf[i];
      w.last = (i == str_buf.size() - 1);
      pending_words.push_back(w);
    end
    words_queued += str_buf.size();
    strings_sent++;
    str_buf.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int unsigned budget;
    logic [4:0]  len;
    text_if.valid = 1'b0;
    text_if.text_byte = '0;
    text_if.final_byte = 1'b0;
    verdict_if.ready = 1'b0;
    tok_lo = '0;
    tok_hi = '0;
    tok_len = '0;
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings on a three-character token spanning the printable extremes.
    program_token(64'h0000_0000_0041_207E, 64'h0, 5'd3);
    push_text("\\challenge\\"); add_token_value(0); flush_string();
    push_text("\\CHALLENGE\\"); add_token_value(0); push_text("\\x\\"); flush_string();
    push_text("\\cHaLlEnGe\\"); add_token_value(0); push_text("\\"); flush_string();
    push_text("\\challenge\\"); add_token_value(0); push_text("\\ch"); flush_string();
    push_text("\\\\challenge\\"); add_token_value(0); flush_string();
    push_text("\\challenge\\"); str_buf.push_back(8'h00); flush_string();
    push_text("\\a\\"); str_buf.push_back(8'hFF); push_text("\\challenge\\");
    add_token_value(0); flush_string();
    push_text("\\a\"b\\c\\challenge\\"); add_token_value(0); flush_string();
    push_text("\\challenge\\"); add_token_value(0); push_text("\\b\\c;d"); flush_string();
    push_text("\\challenge\\"); add_token_value(0); push_text("\\challenge\\");
    add_token_value(0); flush_string();
    push_text("\\challengex\\"); add_token_value(0); flush_string();
    push_text("\\challenge\\~ a"); flush_string();
    push_text("\\"); flush_string();
    push_text("x"); flush_string();
    // The shortest overlong string, otherwise well formed.
    build_long(isc_pkg::MaxInfo); flush_string();
    drain();

    // Random strings under a series of token settings.
    for (int unsigned ph = 0; ph < NumSettings; ph++) begin
      case (ph)
        0: program_token(rand_plain_half(), rand_plain_half(), 5'd16);
        1: program_token(rand_plain_half(), rand_plain_half(), 5'd1);
        2: program_token(64'h0, 64'h0, 5'd0);
        3: program_token(rand_plain_half(), rand_plain_half(), 5'd31);
        4: program_token('1, '1, 5'd16);
        5: begin
          len = 5'($urandom_range(1, 16));
          program_token({$urandom, $urandom}, {$urandom, $urandom}, len);
        end
        6: program_token(rand_plain_half(), rand_plain_half(), 5'd17);
        default: begin
          len = 5'($urandom_range(1, 15));
          program_token(rand_plain_half(), rand_plain_half(), len);
        end
      endcase
      no_idle = (ph % 3 == 2);
      budget = words_queued + WordsPerSetting;
      while (words_queued < budget) begin
        make_random_string();
        flush_string();
      end
      drain();
    end

    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
      fault_count++;
    end
    $display("Ran %0d strings (%0d text words) across %0d token settings.",
             strings_sent, words_queued, NumSettings + 1);
    $display("Verdicts seen: %0d accepted, %0d rejected; %0d mismatches.",
             verdicts_ok, verdicts_rejected, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/isc_pkg.sv
hw/rtl/isc_if.sv
hw/rtl/isc_cfg_regs.sv
hw/rtl/isc_parser.sv
hw/rtl/info_string_token_checker.sv
hw/rtl/isc_checker.sv
tb/sv/info_string_token_checker_tb.sv
